// ----- rtl/core/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tbp_pkg: shared types and constants of the tournament branch predictor
// Beat layouts, 2-bit counter codes and history limits.
// ----------------------------------------------------------------------------
package tbp_pkg;

  // 2-bit saturating counter
  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_MAX     = 2'd3;
  localparam ctr_t CTR_TAKEN   = 2'd2;
  localparam ctr_t CTR_BIM_RST = 2'd1;
  localparam ctr_t CTR_GSH_RST = 2'd1;
  localparam ctr_t CTR_CHO_RST = 2'd2;

  // global history limits and history length register
  localparam int unsigned HIST_W = 11;
  localparam int unsigned HB_W   = 4;
  localparam logic [HB_W-1:0] HB_MAX = 4'd11;
  localparam logic [HB_W-1:0] HB_RST = 4'd11;

  // width of the reported correct count
  localparam int unsigned OUT_CNT_W = 32;

  // input beat: one resolved branch
  typedef struct packed {
    logic [63:0] branch_addr;
    logic        taken;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic                 predicted_taken;
    logic                 used_gshare;
    logic                 correct;
    logic [OUT_CNT_W-1:0] correct_count;
  } out_beat_t;

  // training decision for one branch
  typedef struct packed {
    logic pred;
    logic use_gsh;
    logic ok;
    ctr_t bim_nxt;
    ctr_t gsh_nxt;
    ctr_t cho_nxt;
  } train_res_t;

endpackage

// ----- rtl/core/tbp_table.sv -----
// ----------------------------------------------------------------------------
// tbp_table: counter table memory with write-to-read forwarding
// One write port and one read port, read data registered. A read issued at
// the same edge as a write to the same entry returns the written data.
// ----------------------------------------------------------------------------
module tbp_table #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned W     = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [W-1:0]             rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [W-1:0]             wr_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_q_r;
  logic [W-1:0] fwd_data_r;
  logic         fwd_hit_r;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, reads old data on a same-edge write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // capture a colliding write so the reader sees the new value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (rd_en) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_q_r;

endmodule

// ----- rtl/core/tbp_train.sv -----
// ----------------------------------------------------------------------------
// tbp_train: prediction and counter training for one branch
// Picks bimodal or gshare by the chooser, trains both predictors toward the
// outcome and moves the chooser toward the one that alone was right.
// ----------------------------------------------------------------------------
module tbp_train (
  input  tbp_pkg::ctr_t       bim_ctr,
  input  tbp_pkg::ctr_t       gsh_ctr,
  input  tbp_pkg::ctr_t       cho_ctr,
  input  logic                taken,
  output tbp_pkg::train_res_t res
);
  import tbp_pkg::*;

  // saturating step of a 2-bit counter
  function automatic ctr_t train(input ctr_t c, input logic up);
    ctr_t r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == 2'd0) ? 2'd0 : c - 2'd1;
    end
    return r;
  endfunction

  logic bim_pred;
  logic gsh_pred;
  logic bim_ok;
  logic gsh_ok;

  always_comb begin
    bim_pred    = bim_ctr >= CTR_TAKEN;
    gsh_pred    = gsh_ctr >= CTR_TAKEN;
    bim_ok      = bim_pred == taken;
    gsh_ok      = gsh_pred == taken;
    res.use_gsh = cho_ctr < CTR_TAKEN;
    res.pred    = res.use_gsh ? gsh_pred : bim_pred;
    res.ok      = res.pred == taken;
    res.bim_nxt = train(bim_ctr, taken);
    res.gsh_nxt = train(gsh_ctr, taken);
    // chooser counts up toward bimodal, down toward gshare
    if (bim_ok && !gsh_ok) begin
      res.cho_nxt = train(cho_ctr, 1'b1);
    end else if (gsh_ok && !bim_ok) begin
      res.cho_nxt = train(cho_ctr, 1'b0);
    end else begin
      res.cho_nxt = cho_ctr;
    end
  end

endmodule

// ----- rtl/core/tournament_branch_predictor_unit.sv -----
// ----------------------------------------------------------------------------
// tournament_branch_predictor_unit: gshare / bimodal tournament predictor
//
// Input channel (in_valid, in_stall, in_data): one resolved branch per beat,
// its address and actual direction. Result channel (out_valid, out_stall,
// out_data): one beat per branch with the chosen prediction, the predictor
// that was used, whether it was right and the running correct count.
// cfg_wr_en / cfg_wr_data set the history length (0..11, higher acts as 11);
// write it only while the block is idle.
//
// Throughput is one branch per cycle while out_stall is low. A branch reads
// its table entries at the accept edge, is trained in the training stage
// and written back, and its result beat is registered at the write-back
// edge. A write to an entry the next branch reads is forwarded in the table.
// The bimodal and chooser counters share one memory, gshare has the other.
//
// After reset a clearing pass writes every table entry with in_stall held
// high; configuration writes are taken meanwhile.
// When out_stall holds a result, one more branch is accepted into the
// training stage and then in_stall rises until the result beat is taken.
// TABLE_ENTRIES must be a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_unit #(
  parameter int unsigned TABLE_ENTRIES = 2048,
  parameter int unsigned COUNT_BITS    = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  tbp_pkg::in_beat_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output tbp_pkg::out_beat_t      out_data,
  input  logic                    cfg_wr_en,
  input  logic [tbp_pkg::HB_W-1:0] cfg_wr_data
);
  import tbp_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  typedef logic [IW-1:0] idx_t;

  // control and state registers
  logic                  clearing_r;
  idx_t                  clr_idx_r;
  logic [HB_W-1:0]       hist_bits_r;
  logic [HIST_W-1:0]     hist_r;
  logic [COUNT_BITS-1:0] hit_r;
  logic [COUNT_BITS-1:0] hit_nxt;
  logic                  s1_valid_r;
  idx_t                  s1_bi_r;
  idx_t                  s1_gi_r;
  logic                  s1_taken_r;
  logic                  out_valid_r;
  out_beat_t             out_data_r;

  logic                  accept;
  logic                  s1_adv;
  logic [HB_W-1:0]       hist_len;
  logic [HIST_W-1:0]     hist_mask;
  idx_t                  bi;
  idx_t                  gi;
  logic [3:0]            bc_rd;
  logic [3:0]            bc_wr;
  ctr_t                  gsh_rd;
  ctr_t                  gsh_wr;
  logic                  tab_wr_en;
  idx_t                  bc_wr_addr;
  idx_t                  gsh_wr_addr;
  train_res_t            res;
  logic [63:0]           hit_ext;

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  // table indexes
  always_comb begin
    hist_len  = (hist_bits_r > HB_MAX) ? HB_MAX : hist_bits_r;
    hist_mask = ~({HIST_W{1'b1}} << hist_len);
    bi        = in_data.branch_addr[IW-1:0];
    gi        = idx_t'(32'(bi) ^ 32'(hist_r & hist_mask));
  end

  // history length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_bits_r <= HB_RST;
    end else if (cfg_wr_en) begin
      hist_bits_r <= cfg_wr_data;
    end
  end

  // global history, updated as each branch is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (accept) begin
      hist_r <= {hist_r[HIST_W-2:0], in_data.taken} & hist_mask;
    end
  end

  // clearing pass over both tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + idx_t'(1);
      if (clr_idx_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // table write port mux: clearing pass or write-back of the trained entry
  always_comb begin
    tab_wr_en   = clearing_r || s1_adv;
    bc_wr_addr  = clearing_r ? clr_idx_r : s1_bi_r;
    gsh_wr_addr = clearing_r ? clr_idx_r : s1_gi_r;
    bc_wr       = clearing_r ? {CTR_CHO_RST, CTR_BIM_RST} : {res.cho_nxt, res.bim_nxt};
    gsh_wr      = clearing_r ? CTR_GSH_RST : res.gsh_nxt;
  end

  // bimodal and chooser counters, {chooser, bimodal}
  tbp_table #(
    .DEPTH (TABLE_ENTRIES),
    .W     (4)
  ) u_bc_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (bi),
    .rd_data (bc_rd),
    .wr_en   (tab_wr_en),
    .wr_addr (bc_wr_addr),
    .wr_data (bc_wr)
  );

  // gshare counters
  tbp_table #(
    .DEPTH (TABLE_ENTRIES),
    .W     (2)
  ) u_gsh_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (gi),
    .rd_data (gsh_rd),
    .wr_en   (tab_wr_en),
    .wr_addr (gsh_wr_addr),
    .wr_data (gsh_wr)
  );

  // training stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bi_r    <= bi;
      s1_gi_r    <= gi;
      s1_taken_r <= in_data.taken;
    end
  end

  tbp_train u_train (
    .bim_ctr (bc_rd[1:0]),
    .gsh_ctr (gsh_rd),
    .cho_ctr (bc_rd[3:2]),
    .taken   (s1_taken_r),
    .res     (res)
  );

  // saturating hit counter
  assign hit_nxt = (res.ok && (hit_r != '1)) ? hit_r + COUNT_BITS'(1) : hit_r;
  assign hit_ext = 64'(hit_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else if (s1_adv) begin
      hit_r <= hit_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.predicted_taken <= res.pred;
      out_data_r.used_gshare     <= res.use_gsh;
      out_data_r.correct         <= res.ok;
      out_data_r.correct_count   <= (|hit_ext[63:OUT_CNT_W]) ? '1 : hit_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s1_valid_r && !out_valid_r)
    else $error("pipeline busy during clearing pass");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_bi_r) && $stable(s1_gi_r))
    else $error("training stage lost a held branch");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted branch did not reach training stage");

  a_hit_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(hit_r))
    else $error("hit counter moved without a trained branch");

endmodule
